// ===== rtl/core/rgts_pkg.sv =====
// Shared types and constants of the RGB565 grayscale / threshold / half-scale core.
package rgts_pkg;

  localparam int unsigned PixelW     = 16;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned ThreshW    = 8;
  localparam int unsigned LineWidthW = 11;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned LumaW      = 5;
  localparam int unsigned LumaSumW   = 15;
  localparam int unsigned LumaShift  = 10;

  localparam logic [LumaSumW-1:0] CoefR = LumaSumW'(190);
  localparam logic [LumaSumW-1:0] CoefG = LumaSumW'(370);
  localparam logic [LumaSumW-1:0] CoefB = LumaSumW'(70);

  localparam logic [PixelW-1:0] PixelBlack = 16'h0000;
  localparam logic [PixelW-1:0] PixelWhite = 16'hFFFF;

  typedef enum logic [ModeW-1:0] {
    MODE_GRAY   = 2'd0,
    MODE_BINARY = 2'd1,
    MODE_HALF   = 2'd2,
    MODE_PASS   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE       = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_LINE_WIDTH = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  localparam mode_e                 ModeReset      = MODE_GRAY;
  localparam logic [ThreshW-1:0]    ThreshReset    = 8'd17;
  localparam logic [LineWidthW-1:0] LineWidthReset = 11'd320;

  // Luma as a weighted sum of the RGB565 fields, scaled down by 1024.
  function automatic logic [LumaW-1:0] luma_of(input logic [PixelW-1:0] px);
    logic [LumaSumW-1:0] sum;
    sum = CoefR * LumaSumW'(px[15:11])
        + CoefG * LumaSumW'(px[10:5])
        + CoefB * LumaSumW'(px[4:0]);
    return LumaW'(sum >> LumaShift);
  endfunction

endpackage

// ===== rtl/core/rgts_in_if.sv =====
// Input pixel channel: valid/ready handshake with pixel and frame-start flag.
interface rgts_in_if;
  logic                           valid;
  logic                           ready;
  logic [rgts_pkg::PixelW-1:0]    pixel_in;
  logic                           frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

// ===== rtl/core/rgts_out_if.sv =====
// Output pixel channel: valid/ready handshake with the processed pixel.
interface rgts_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgts_pkg::PixelW-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== rtl/core/rgts_grid.sv =====
// Column and row-parity tracker that marks pixels on even rows and even columns.
module rgts_grid #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              frame_start_i,
  input  logic [rgts_pkg::LineWidthW-1:0]   line_width_i,
  output logic                              keep_o
);

  localparam int unsigned CntW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned CmpW = (CntW + 1 > rgts_pkg::LineWidthW) ?
                                 CntW + 1 : rgts_pkg::LineWidthW;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MAX_LINE_WIDTH);

  logic [CntW-1:0] column_q, column_d, column_cur;
  logic            row_odd_q, row_odd_d, row_odd_cur;
  logic [CmpW-1:0] width_raw, width_eff, column_inc;

  // A frame-start pixel is column 0 of row 0 regardless of the counters.
  assign column_cur  = frame_start_i ? '0 : column_q;
  assign row_odd_cur = frame_start_i ? 1'b0 : row_odd_q;
  assign keep_o      = !row_odd_cur && !column_cur[0];

  assign width_raw = CmpW'(line_width_i);

  always_comb begin
    if (width_raw == '0) begin
      width_eff = CmpW'(1);
    end else if (width_raw > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = width_raw;
    end
    column_inc = CmpW'(column_cur) + CmpW'(1);
    if (column_inc >= width_eff) begin
      column_d  = '0;
      row_odd_d = !row_odd_cur;
    end else begin
      column_d  = CntW'(column_inc);
      row_odd_d = row_odd_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q  <= '0;
      row_odd_q <= 1'b0;
    end else if (accept_i) begin
      column_q  <= column_d;
      row_odd_q <= row_odd_d;
    end
  end

`ifndef SYNTH
  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(column_q) < MaxW)
    else $error("column counter beyond the maximum line width");

  a_frame_start_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && frame_start_i |=>
      (column_q == CntW'(1) && !row_odd_q) || (column_q == '0 && row_odd_q))
    else $error("frame start did not restart the pixel grid");
`endif

endmodule

// ===== rtl/core/rgts_pixel_op.sv =====
// Per-pixel operation: grayscale, binarize or pass-through, selected by mode.
module rgts_pixel_op (
  input  logic [rgts_pkg::PixelW-1:0]  pixel_i,
  input  rgts_pkg::mode_e              mode_i,
  input  logic [rgts_pkg::ThreshW-1:0] threshold_i,
  output logic [rgts_pkg::PixelW-1:0]  pixel_o
);

  logic [rgts_pkg::LumaW-1:0] luma;

  assign luma = rgts_pkg::luma_of(pixel_i);

  always_comb begin
    case (mode_i)
      rgts_pkg::MODE_GRAY: begin
        // Luma replicated into all three fields; green bit 0 stays clear.
        pixel_o = {luma, luma, 1'b0, luma};
      end
      rgts_pkg::MODE_BINARY: begin
        pixel_o = (rgts_pkg::ThreshW'(luma) <= threshold_i) ?
                  rgts_pkg::PixelBlack : rgts_pkg::PixelWhite;
      end
      default: begin
        pixel_o = pixel_i;
      end
    endcase
  end

endmodule

// ===== rtl/core/rgb565_gray_threshold_scaler_core.sv =====
// Top level of the RGB565 grayscale / threshold / half-scale pixel core.
//
// Streaming RGB565 pixel processor. Every transfer on pix_i carries one pixel and a
// frame-start flag; the core computes luma (190R + 370G + 70B) >> 10 and, by the mode
// register, sends out a gray pixel, a black or white pixel (luma at or below the
// threshold gives black), or the original pixel for half-scale decimation, where only
// pixels on even rows and even columns of a line_width-wide frame produce a transfer
// on pix_o. Mode 3 passes every pixel unchanged. The column and row counters run in
// all modes and restart on frame start; a line width of 0 or 1 acts as 1, one above
// MAX_LINE_WIDTH acts as MAX_LINE_WIDTH. The core takes one pixel per clock cycle
// sustained while the output is not stalled: a pixel is registered at the input,
// processed by one level of logic (the small luma multiply-add and mode select) and
// registered at the output. Each stage has its own valid flag, so a stalled output
// does not block input until both stages are full. The user must write configuration
// through cfg_we_i / cfg_idx_i / cfg_data_i only while the core is idle (unenforced).
module rgb565_gray_threshold_scaler_core #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgts_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rgts_pkg::CfgDataW-1:0]   cfg_data_i,
  rgts_in_if.sink                         pix_i,
  rgts_out_if.source                      pix_o
);

  // Configuration registers.
  rgts_pkg::mode_e                  mode_q;
  logic [rgts_pkg::ThreshW-1:0]     threshold_q;
  logic [rgts_pkg::LineWidthW-1:0]  line_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= rgts_pkg::ModeReset;
      threshold_q  <= rgts_pkg::ThreshReset;
      line_width_q <= rgts_pkg::LineWidthReset;
    end else if (cfg_we_i) begin
      case (rgts_pkg::cfg_idx_e'(cfg_idx_i))
        rgts_pkg::CFG_MODE: begin
          mode_q <= rgts_pkg::mode_e'(cfg_data_i[rgts_pkg::ModeW-1:0]);
        end
        rgts_pkg::CFG_THRESHOLD: begin
          threshold_q <= cfg_data_i[rgts_pkg::ThreshW-1:0];
        end
        rgts_pkg::CFG_LINE_WIDTH: begin
          line_width_q <= cfg_data_i[rgts_pkg::LineWidthW-1:0];
        end
        default: begin
          // Writes to an index beyond the register list are dropped.
        end
      endcase
    end
  end

  // Handshake control for the two register stages.
  logic in_accept;
  logic s1_valid_q, s1_adv, s1_emit;
  logic s2_valid_q, s2_ready;
  logic grid_keep;

  logic                         s1_keep_q;
  logic [rgts_pkg::PixelW-1:0]  s1_pixel_q;
  logic [rgts_pkg::PixelW-1:0]  s2_pixel_d, s2_pixel_q;

  assign s2_ready  = !s2_valid_q || pix_o.ready;
  // Decimated pixels are dropped here and need no room in the output register.
  assign s1_emit   = (mode_q != rgts_pkg::MODE_HALF) || s1_keep_q;
  assign s1_adv    = s1_valid_q && (!s1_emit || s2_ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_accept = pix_i.valid && pix_i.ready;

  // The grid tracker updates at every input transfer and flags even/even pixels.
  rgts_grid #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_grid (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .frame_start_i (pix_i.frame_start),
    .line_width_i  (line_width_q),
    .keep_o        (grid_keep)
  );

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pix_i.pixel_in;
      s1_keep_q  <= grid_keep;
    end
  end

  rgts_pixel_op u_pixel_op (
    .pixel_i     (s1_pixel_q),
    .mode_i      (mode_q),
    .threshold_i (threshold_q),
    .pixel_o     (s2_pixel_d)
  );

  // Output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      s2_pixel_q <= s2_pixel_d;
    end
  end

  assign pix_o.valid     = s2_valid_q;
  assign pix_o.pixel_out = s2_pixel_q;

`ifndef SYNTH
  a_in_transfer_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted pixel missing from the input stage");

  a_emit_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit && s2_ready |=> s2_valid_q)
    else $error("emitted pixel missing from the output stage");

  a_backpressure_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> s1_valid_q && s2_valid_q && !pix_o.ready)
    else $error("input stalled while a stage had room");
`endif

endmodule
